### rtl/core/http_body_to_flash_pages_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the HTTP body to flash page block
// ---------------------------------------------------------------------------
`ifndef HTTP_BODY_TO_FLASH_PAGES_TOP_MACROS_SVH
`define HTTP_BODY_TO_FLASH_PAGES_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define HB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/hbfp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hbfp_pkg
// Types, codes and constants of the HTTP body to flash page block.
// ---------------------------------------------------------------------------
package hbfp_pkg;

    localparam int PAGE_BYTES_DEF   = 2048;
    localparam int HEADER_MAX_DEF   = 512;
    localparam int REGION_BYTES_DEF = 507904;

    localparam logic [31:0] BASE_ADDRESS_RST = 32'h0800_4000;

    localparam int KIND_W  = 3;
    localparam int KEY_W   = 4;
    localparam int KEY_LEN = 15;

    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] PAD_BYTE  = 8'hFF;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_STOP
    } phase_t;

    typedef enum logic [1:0] {
        NUM_NOKEY,
        NUM_SPACE,
        NUM_DIGITS,
        NUM_DONE
    } num_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ERASE   = 3'd0,
        KIND_PROGRAM = 3'd1,
        KIND_PAD     = 3'd2,
        KIND_FAIL    = 3'd3,
        KIND_DONE    = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] address;
        logic [15:0] halfword;
        logic        length_ok;
        logic        last;
    } res_t;

    // "Content-Length:"
    function automatic logic [7:0] key_char(input logic [KEY_W-1:0] idx);
        case (idx)
            4'd0:    key_char = 8'h43;
            4'd1:    key_char = 8'h6F;
            4'd2:    key_char = 8'h6E;
            4'd3:    key_char = 8'h74;
            4'd4:    key_char = 8'h65;
            4'd5:    key_char = 8'h6E;
            4'd6:    key_char = 8'h74;
            4'd7:    key_char = 8'h2D;
            4'd8:    key_char = 8'h4C;
            4'd9:    key_char = 8'h65;
            4'd10:   key_char = 8'h6E;
            4'd11:   key_char = 8'h67;
            4'd12:   key_char = 8'h74;
            4'd13:   key_char = 8'h68;
            4'd14:   key_char = 8'h3A;
            default: key_char = 8'h00;
        endcase
    endfunction

endpackage

### rtl/core/http_body_to_flash_pages_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// http_body_to_flash_pages_top
// HTTP response byte stream to flash erase / program / pad commands.
// ---------------------------------------------------------------------------
// One word enters per clock while decode is not held by the queue. It is held
// in an input register, decoded by one level of logic against the parser state
// and its results (0 to 3) are pushed into a 4-deep result queue that drains one
// word per clock while out_ready is high. Input is taken whenever the input
// register is free or its word is being decoded; decode waits while the queue
// holds more than one word, so a byte stream runs at one byte per cycle while
// out_ready is high.
`include "http_body_to_flash_pages_top_macros.svh"

module http_body_to_flash_pages_top #(
    parameter int PAGE_BYTES   = hbfp_pkg::PAGE_BYTES_DEF,
    parameter int HEADER_MAX   = hbfp_pkg::HEADER_MAX_DEF,
    parameter int REGION_BYTES = hbfp_pkg::REGION_BYTES_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [31:0]                            cfg_wr_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   action,
    input  logic [7:0]                             byte_value,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [hbfp_pkg::KIND_W-1:0]            kind,
    output logic [31:0]                            address,
    output logic [15:0]                            halfword,
    output logic [$clog2(REGION_BYTES+1)-1:0]      byte_count,
    output logic                                   length_ok,
    output logic                                   last
);
    import hbfp_pkg::*;

    localparam int CNT_W  = $clog2(REGION_BYTES + 1);
    localparam int HDR_W  = $clog2(HEADER_MAX + 1);
    localparam int PG_W   = $clog2(PAGE_BYTES);
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;
    localparam int NRES   = 3;

    localparam logic [CNT_W-1:0]   REGION_C = CNT_W'(REGION_BYTES);
    localparam logic [HDR_W-1:0]   HMAX_C   = HDR_W'(HEADER_MAX);
    localparam logic [PG_W:0]      PAGE_C   = (PG_W+1)'(PAGE_BYTES);

    // configuration
    logic [31:0]      base_reg, base_next;

    // input register
    logic             in_vld_reg, in_vld_next;
    logic             in_act_reg, in_act_next;
    logic [7:0]       in_byte_reg, in_byte_next;

    // parser state
    phase_t           phase_reg, phase_next;
    logic [1:0]       bl_reg, bl_next;
    logic [HDR_W-1:0] hs_reg, hs_next;
    logic [KEY_W-1:0] kp_reg, kp_next;
    num_t             num_reg, num_next;
    logic [CNT_W-1:0] cl_reg, cl_next;
    logic [CNT_W-1:0] bb_reg, bb_next;
    logic [PG_W-1:0]  pg_reg, pg_next;
    logic [7:0]       held_reg, held_next;

    // result queue
    res_t              q_reg [QDEPTH];
    res_t              q_next [QDEPTH];
    logic [CNT_W-1:0]  qc_reg [QDEPTH];
    logic [CNT_W-1:0]  qc_next [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    // decode
    logic             proc;
    logic             pop;
    logic             is_digit;
    logic [3:0]       digit;
    logic [HDR_W-1:0] hs_inc;
    logic [7:0]       bl_want;
    logic [2:0]       bl_new;
    logic             blank_done;
    logic             hdr_fail;
    logic [KEY_W:0]   kp_adv;
    logic [CNT_W+3:0] cl_x10;
    logic [CNT_W-1:0] cl_sat;
    logic             body_take;
    logic             odd;
    logic [PG_W:0]    pg_plus;
    logic [PG_W-1:0]  pg_wrap;
    logic [PG_W-1:0]  end_pg;
    logic [31:0]      off32;
    logic [31:0]      addr_cur;
    logic [31:0]      addr_even;
    logic [31:0]      addr_pad;
    res_t             res [NRES];
    logic [CNT_W-1:0] res_cnt [NRES];
    logic [1:0]       n_res;

    assign pop      = out_valid & out_ready;
    assign proc     = in_vld_reg && (cnt_reg <= QCNT_W'(1));
    assign in_ready = !in_vld_reg || proc;

    assign is_digit   = (in_byte_reg >= CHR_ZERO) && (in_byte_reg <= CHR_NINE);
    assign digit      = 4'(in_byte_reg - CHR_ZERO);
    assign hs_inc     = (hs_reg < HMAX_C) ? hs_reg + HDR_W'(1) : hs_reg;
    assign bl_want    = bl_reg[0] ? CHR_LF : CHR_CR;
    assign bl_new     = (in_byte_reg == bl_want) ? {1'b0, bl_reg} + 3'd1 :
                        ((in_byte_reg == CHR_CR) ? 3'd1 : 3'd0);
    assign blank_done = bl_new[2];
    assign hdr_fail   = !blank_done && (hs_inc >= HMAX_C);

    // restart on the first key letter after a mismatch
    assign kp_adv = (in_byte_reg == key_char(kp_reg)) ? {1'b0, kp_reg} + (KEY_W+1)'(1) :
                    ((in_byte_reg == key_char('0)) ? (KEY_W+1)'(1) : '0);

    // value * 10 + digit, clipped to the region
    assign cl_x10 = ({4'd0, cl_reg} << 3) + ({4'd0, cl_reg} << 1) + (CNT_W+4)'(digit);
    assign cl_sat = (cl_x10 > (CNT_W+4)'(REGION_BYTES)) ? REGION_C : cl_x10[CNT_W-1:0];

    assign body_take = (phase_reg == PH_BODY) && !in_act_reg && (bb_reg < cl_reg);
    assign odd       = bb_reg[0];
    assign pg_plus   = {1'b0, pg_reg} + (PG_W+1)'(1);
    assign pg_wrap   = (pg_plus == PAGE_C) ? '0 : pg_plus[PG_W-1:0];
    assign end_pg    = odd ? pg_wrap : pg_reg;

    assign off32     = 32'(bb_reg);
    assign addr_cur  = base_reg + off32;
    assign addr_even = base_reg + (off32 & ~32'd1);
    assign addr_pad  = base_reg + off32 + 32'(odd);

    // next state
    always_comb
    begin
        base_next    = cfg_wr_en ? cfg_wr_data : base_reg;
        in_vld_next  = in_vld_reg;
        in_act_next  = in_act_reg;
        in_byte_next = in_byte_reg;
        if (in_valid && in_ready)
        begin
            in_vld_next  = 1'b1;
            in_act_next  = action;
            in_byte_next = byte_value;
        end
        else if (proc)
        begin
            in_vld_next = 1'b0;
        end

        phase_next = phase_reg;
        bl_next    = bl_reg;
        hs_next    = hs_reg;
        kp_next    = kp_reg;
        num_next   = num_reg;
        cl_next    = cl_reg;
        bb_next    = bb_reg;
        pg_next    = pg_reg;
        held_next  = held_reg;

        if (proc)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (in_act_reg)
                    begin
                        phase_next = PH_STOP;
                    end
                    else
                    begin
                        hs_next = hs_inc;
                        case (num_reg)
                            NUM_NOKEY:
                            begin
                                if (kp_adv == (KEY_W+1)'(KEY_LEN))
                                begin
                                    kp_next  = '0;
                                    num_next = NUM_SPACE;
                                end
                                else
                                begin
                                    kp_next = kp_adv[KEY_W-1:0];
                                end
                            end
                            NUM_SPACE:
                            begin
                                if (in_byte_reg == CHR_SPACE || in_byte_reg == CHR_TAB)
                                begin
                                    num_next = NUM_SPACE;
                                end
                                else if (in_byte_reg == CHR_PLUS)
                                begin
                                    num_next = NUM_DIGITS;
                                end
                                else if (is_digit)
                                begin
                                    cl_next  = CNT_W'(digit);
                                    num_next = NUM_DIGITS;
                                end
                                else
                                begin
                                    cl_next  = '0;
                                    num_next = NUM_DONE;
                                end
                            end
                            NUM_DIGITS:
                            begin
                                if (is_digit)
                                    cl_next = cl_sat;
                                else
                                    num_next = NUM_DONE;
                            end
                            default:
                            begin
                                num_next = num_reg;
                            end
                        endcase

                        bl_next = bl_new[1:0];
                        if (blank_done)
                        begin
                            bl_next = '0;
                            if (num_reg == NUM_SPACE || num_reg == NUM_DIGITS ||
                                num_next == NUM_SPACE)
                                num_next = NUM_DONE;
                            phase_next = PH_BODY;
                        end
                        else if (hdr_fail)
                        begin
                            phase_next = PH_STOP;
                        end
                    end
                end
                PH_BODY:
                begin
                    if (in_act_reg)
                    begin
                        phase_next = PH_STOP;
                    end
                    else if (body_take)
                    begin
                        if (!odd)
                            held_next = in_byte_reg;
                        bb_next = bb_reg + CNT_W'(1);
                        pg_next = pg_wrap;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // results of the word being decoded
    always_comb
    begin
        logic [1:0] idx;
        idx = '0;
        for (int i = 0; i < NRES; i++)
        begin
            res[i]     = '{kind: KIND_ERASE, address: '0, halfword: '0,
                           length_ok: 1'b0, last: 1'b0};
            res_cnt[i] = '0;
        end

        if (proc)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (in_act_reg || (!blank_done && hdr_fail))
                    begin
                        res[0].kind = KIND_FAIL;
                        idx = 2'd1;
                    end
                end
                PH_BODY:
                begin
                    if (!in_act_reg)
                    begin
                        if (body_take)
                        begin
                            if (pg_reg == '0)
                            begin
                                res[idx].kind    = KIND_ERASE;
                                res[idx].address = addr_cur;
                                idx = idx + 2'd1;
                            end
                            if (odd)
                            begin
                                res[idx].kind     = KIND_PROGRAM;
                                res[idx].address  = addr_even;
                                res[idx].halfword = {in_byte_reg, held_reg};
                                idx = idx + 2'd1;
                            end
                        end
                    end
                    else
                    begin
                        // odd tail byte goes out padded
                        if (odd)
                        begin
                            res[idx].kind     = KIND_PROGRAM;
                            res[idx].address  = addr_even;
                            res[idx].halfword = {PAD_BYTE, held_reg};
                            idx = idx + 2'd1;
                        end
                        if (end_pg != '0)
                        begin
                            res[idx].kind    = KIND_PAD;
                            res[idx].address = addr_pad;
                            idx = idx + 2'd1;
                        end
                        res[idx].kind      = KIND_DONE;
                        res[idx].length_ok = (bb_reg == cl_reg);
                        res_cnt[idx]       = bb_reg;
                        idx = idx + 2'd1;
                    end
                end
                default:
                begin
                    idx = '0;
                end
            endcase
        end

        for (int i = 0; i < NRES; i++)
            res[i].last = (idx != 2'd0) && (2'(i) == idx - 2'd1);
        n_res = idx;
    end

    // result queue
    always_comb
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            q_next[i]  = q_reg[i];
            qc_next[i] = qc_reg[i];
        end
        for (int i = 0; i < NRES; i++)
        begin
            if (2'(i) < n_res)
            begin
                q_next[wr_reg + QPTR_W'(i)]  = res[i];
                qc_next[wr_reg + QPTR_W'(i)] = res_cnt[i];
            end
        end
        wr_next  = wr_reg + QPTR_W'(n_res);
        rd_next  = rd_reg + QPTR_W'(pop);
        cnt_next = cnt_reg + QCNT_W'(n_res) - QCNT_W'(pop);
    end

    assign out_valid  = (cnt_reg != '0);
    assign kind       = q_reg[rd_reg].kind;
    assign address    = q_reg[rd_reg].address;
    assign halfword   = q_reg[rd_reg].halfword;
    assign byte_count = qc_reg[rd_reg];
    assign length_ok  = q_reg[rd_reg].length_ok;
    assign last       = q_reg[rd_reg].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= BASE_ADDRESS_RST;
            in_vld_reg <= 1'b0;
            phase_reg  <= PH_HEADER;
            bl_reg     <= '0;
            hs_reg     <= '0;
            kp_reg     <= '0;
            num_reg    <= NUM_NOKEY;
            cl_reg     <= '0;
            bb_reg     <= '0;
            pg_reg     <= '0;
            held_reg   <= '0;
            wr_reg     <= '0;
            rd_reg     <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            base_reg   <= base_next;
            in_vld_reg <= in_vld_next;
            phase_reg  <= phase_next;
            bl_reg     <= bl_next;
            hs_reg     <= hs_next;
            kp_reg     <= kp_next;
            num_reg    <= num_next;
            cl_reg     <= cl_next;
            bb_reg     <= bb_next;
            pg_reg     <= pg_next;
            held_reg   <= held_next;
            wr_reg     <= wr_next;
            rd_reg     <= rd_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_act_reg  <= in_act_next;
        in_byte_reg <= in_byte_next;
        for (int i = 0; i < QDEPTH; i++)
        begin
            q_reg[i]  <= q_next[i];
            qc_reg[i] <= qc_next[i];
        end
    end

    `HB_ASSERT_IMP(a_queue_bound, 1'b1, cnt_reg <= QCNT_W'(QDEPTH), "result queue overrun")
    `HB_ASSERT_NXT(a_stop_holds, phase_reg == PH_STOP, phase_reg == PH_STOP, "left stopped phase")
    `HB_ASSERT_IMP(a_body_bound, phase_reg == PH_BODY, bb_reg <= cl_reg, "body count past length")
    `HB_ASSERT_NXT(a_end_stops, proc && phase_reg == PH_BODY && in_act_reg,
                   phase_reg == PH_STOP, "end of stream did not stop")

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Feeds one HTTP response through the body-to-flash block: a header whose
// Content-Length is parsed, then body words, then an end of stream. The
// expected erase, program, pad and finish commands are worked out alongside
// and compared word by word against the output. The base address is changed
// between phases, and the phases use no idling, sender gaps, receiver stalls or both.
// ---------------------------------------------------------------------------
module tb_top;

    import hbfp_pkg::*;

    localparam int BYTE_COUNT_W = $clog2(REGION_BYTES_DEF + 1);

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    localparam logic [7:0] CORNER_BYTES [8] = '{
        8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0D, 8'h0A, 8'h20, 8'h2B
    };

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic       act;
        logic [7:0] data;
    } stream_word_t;

    typedef struct packed {
        kind_t                   kind;
        logic [31:0]             address;
        logic [15:0]             halfword;
        logic [BYTE_COUNT_W-1:0] byte_count;
        logic                    length_ok;
        logic                    last;
    } flash_cmd_t;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    cfg_wr_en   = 1'b0;
    logic [31:0]             cfg_wr_data = '0;
    logic                    in_valid    = 1'b0;
    logic                    in_ready;
    logic                    action      = 1'b0;
    logic [7:0]              byte_value  = '0;
    logic                    out_valid;
    logic                    out_ready   = 1'b0;
    logic [KIND_W-1:0]       kind;
    logic [31:0]             address;
    logic [15:0]             halfword;
    logic [BYTE_COUNT_W-1:0] byte_count;
    logic                    length_ok;
    logic                    last;

    stream_word_t words_to_send[$];
    flash_cmd_t   cmds_due[$];
    int           queued_cnt     = 0;
    int           taken_cnt      = 0;
    int           mismatch_cnt   = 0;
    int           send_gap_pct   = 0;
    int           recv_stall_pct = 0;

    // parser state mirrored on the test side
    string       key_text    = "Content-Length:";
    logic [31:0] base_reg    = BASE_ADDRESS_RST;
    phase_t      st_phase    = PH_HEADER;
    num_t        st_num      = NUM_NOKEY;
    int          st_blank    = 0;
    int          st_hdr_seen = 0;
    int          st_key_pos  = 0;
    int          st_clen     = 0;
    int          st_body     = 0;
    logic [7:0]  st_held     = '0;

    http_body_to_flash_pages_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .byte_value  (byte_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .address     (address),
        .halfword    (halfword),
        .byte_count  (byte_count),
        .length_ok   (length_ok),
        .last        (last)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic flash_cmd_t flash_cmd(input kind_t k, input logic [31:0] a,
                                             input logic [15:0] h,
                                             input logic [BYTE_COUNT_W-1:0] c,
                                             input logic ok);
        flash_cmd_t r;
        r.kind       = k;
        r.address    = a;
        r.halfword   = h;
        r.byte_count = c;
        r.length_ok  = ok;
        r.last       = 1'b0;
        return r;
    endfunction

    // works out the commands one accepted word gives and queues them
    task automatic decode_word(input logic act, input logic [7:0] b);
        flash_cmd_t step_cmds[3];
        int         n;
        int         off;
        logic [7:0] blank_want;
        n = 0;
        if (st_phase == PH_HEADER)
        begin
            if (act == ACT_END)
            begin
                step_cmds[n] = flash_cmd(KIND_FAIL, '0, '0, '0, 1'b0);
                n++;
                st_phase = PH_STOP;
            end
            else
            begin
                if (st_hdr_seen < HEADER_MAX_DEF)
                    st_hdr_seen++;
                case (st_num)
                    NUM_NOKEY:
                    begin
                        if (b == key_text[st_key_pos])
                            st_key_pos++;
                        else
                            st_key_pos = (b == key_text[0]) ? 1 : 0;
                        if (st_key_pos >= KEY_LEN)
                        begin
                            st_key_pos = 0;
                            st_num     = NUM_SPACE;
                        end
                    end
                    NUM_SPACE:
                    begin
                        // blanks are skipped, a sign or digit opens the number
                        if (b != CHR_SPACE && b != CHR_TAB)
                        begin
                            if (b == CHR_PLUS)
                                st_num = NUM_DIGITS;
                            else if (b >= CHR_ZERO && b <= CHR_NINE)
                            begin
                                st_clen = int'(b - CHR_ZERO);
                                st_num  = NUM_DIGITS;
                            end
                            else
                            begin
                                st_clen = 0;
                                st_num  = NUM_DONE;
                            end
                        end
                    end
                    NUM_DIGITS:
                    begin
                        if (b >= CHR_ZERO && b <= CHR_NINE)
                        begin
                            st_clen = st_clen * 10 + int'(b - CHR_ZERO);
                            if (st_clen > REGION_BYTES_DEF)
                                st_clen = REGION_BYTES_DEF;
                        end
                        else
                            st_num = NUM_DONE;
                    end
                    default:
                    begin
                    end
                endcase

                blank_want = (st_blank % 2 == 1) ? CHR_LF : CHR_CR;
                if (b == blank_want)
                    st_blank++;
                else
                    st_blank = (b == CHR_CR) ? 1 : 0;

                if (st_blank >= 4)
                begin
                    st_blank = 0;
                    if (st_num != NUM_DONE && st_num != NUM_NOKEY)
                        st_num = NUM_DONE;
                    st_phase = PH_BODY;
                end
                else if (st_hdr_seen >= HEADER_MAX_DEF)
                begin
                    step_cmds[n] = flash_cmd(KIND_FAIL, '0, '0, '0, 1'b0);
                    n++;
                    st_phase = PH_STOP;
                end
            end
        end
        else if (st_phase == PH_BODY)
        begin
            if (act == ACT_BYTE)
            begin
                // words past the length are dropped
                if (st_body < st_clen)
                begin
                    off = st_body;
                    if (off % PAGE_BYTES_DEF == 0)
                    begin
                        step_cmds[n] = flash_cmd(KIND_ERASE, base_reg + 32'(off),
                                                 '0, '0, 1'b0);
                        n++;
                    end
                    if (off % 2 == 1)
                    begin
                        step_cmds[n] = flash_cmd(KIND_PROGRAM, base_reg + 32'(off) - 32'd1,
                                                 {b, st_held}, '0, 1'b0);
                        n++;
                    end
                    else
                        st_held = b;
                    st_body = off + 1;
                end
            end
            else
            begin
                off = st_body;
                if (off % 2 == 1)
                begin
                    step_cmds[n] = flash_cmd(KIND_PROGRAM, base_reg + 32'(off) - 32'd1,
                                             {PAD_BYTE, st_held}, '0, 1'b0);
                    n++;
                    off++;
                end
                if (off % PAGE_BYTES_DEF != 0)
                begin
                    step_cmds[n] = flash_cmd(KIND_PAD, base_reg + 32'(off), '0, '0, 1'b0);
                    n++;
                end
                step_cmds[n] = flash_cmd(KIND_DONE, '0, '0, BYTE_COUNT_W'(st_body),
                                         st_body == st_clen);
                n++;
                st_phase = PH_STOP;
            end
        end

        for (int i = 0; i < n; i++)
        begin
            step_cmds[i].last = (i == n - 1);
            cmds_due.push_back(step_cmds[i]);
        end
    endtask

    task automatic note_mismatch(input string what, input flash_cmd_t want,
                                 input flash_cmd_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display({"tb_top: %s: expected kind=%0d addr=%h hw=%h cnt=%0d ok=%b last=%b",
                      ", got kind=%0d addr=%h hw=%h cnt=%0d ok=%b last=%b"},
                     what, want.kind, want.address, want.halfword, want.byte_count,
                     want.length_ok, want.last,
                     got.kind, got.address, got.halfword, got.byte_count,
                     got.length_ok, got.last);
    endtask

    function automatic void queue_word(input logic act, input logic [7:0] data);
        stream_word_t w;
        w.act  = act;
        w.data = data;
        words_to_send.push_back(w);
        queued_cnt++;
    endfunction

    function automatic void queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_word(ACT_BYTE, s[i]);
    endfunction

    function automatic void queue_crlf();
        queue_word(ACT_BYTE, CHR_CR);
        queue_word(ACT_BYTE, CHR_LF);
    endfunction

    function automatic void queue_noise_line();
        queue_text("X-");
        repeat ($urandom_range(3, 12)) queue_word(ACT_BYTE, 8'h61 + 8'($urandom_range(25)));
        queue_text(": ");
        repeat ($urandom_range(1, 16)) queue_word(ACT_BYTE, 8'h41 + 8'($urandom_range(25)));
        queue_crlf();
    endfunction

    function automatic void queue_random_bytes(input int count);
        repeat (count) queue_word(ACT_BYTE, 8'($urandom));
    endfunction

    function automatic void set_idling(input idle_mode_t m);
        case (m)
            IDLE_SEND:
            begin
                send_gap_pct   = 76;
                recv_stall_pct = 0;
            end
            IDLE_RECV:
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 76;
            end
            IDLE_BOTH:
            begin
                send_gap_pct   = 30;
                recv_stall_pct = 30;
            end
            default:
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
        endcase
    endfunction

    task automatic write_base(input logic [31:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        base_reg = v;
    endtask

    // every word taken and every command seen, then room for a word in flight
    task automatic wait_drained();
        while (taken_cnt != queued_cnt || cmds_due.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : word_driver
        stream_word_t w;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            action     <= ACT_BYTE;
            byte_value <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                decode_word(action, byte_value);
                taken_cnt++;
            end
            if (!in_valid || in_ready)
            begin
                if (words_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    w = words_to_send.pop_front();
                    in_valid   <= 1'b1;
                    action     <= w.act;
                    byte_value <= w.data;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : cmd_checker
        flash_cmd_t got;
        flash_cmd_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {kind, address, halfword, byte_count, length_ok, last};
                if (cmds_due.size() == 0)
                    note_mismatch("word with nothing due", '0, got);
                else
                begin
                    want = cmds_due.pop_front();
                    if (got !== want)
                        note_mismatch("wrong word", want, got);
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : stimulus
        int len_mode;
        int clen_val;
        int body_total;
        set_idling(IDLE_NONE);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        write_base($urandom());

        // header: near-miss key, stray CR, first Content-Length wins
        queue_text("HTTP/1.1 200 OK");
        queue_crlf();
        queue_text("Content-Type: application/octet-stream");
        queue_crlf();
        queue_text("X-Odd: a");
        queue_word(ACT_BYTE, CHR_CR);
        queue_text("Cb");
        queue_crlf();
        repeat ($urandom_range(1)) queue_noise_line();
        len_mode = $urandom_range(9);
        clen_val = $urandom_range(90, 115);
        queue_text("Content-Length:");
        repeat ($urandom_range(3)) queue_word(ACT_BYTE, $urandom_range(1) ? CHR_SPACE : CHR_TAB);
        if (len_mode == 0)
            queue_text($sformatf("-%0d", clen_val));
        else if (len_mode == 1)
            queue_text("+4294967296000");
        else
        begin
            if ($urandom_range(1))
                queue_word(ACT_BYTE, CHR_PLUS);
            queue_text($sformatf("%0d", clen_val));
        end
        queue_crlf();
        queue_text("Content-Length: 7");
        queue_crlf();
        repeat ($urandom_range(1, 2)) queue_noise_line();
        queue_crlf();
        wait_drained();

        body_total = clen_val - 8 + $urandom_range(16);

        // address wraps past the top of the space here
        write_base(32'hFFFF_FFFF);
        foreach (CORNER_BYTES[i]) queue_word(ACT_BYTE, CORNER_BYTES[i]);
        for (int i = 0; i < 8; i++)
            queue_word(ACT_BYTE, 8'h01 << i);
        queue_random_bytes(4);
        wait_drained();

        write_base('0);
        set_idling(IDLE_SEND);
        queue_random_bytes(25);
        wait_drained();

        write_base(BASE_ADDRESS_RST);
        set_idling(IDLE_RECV);
        queue_random_bytes(25);
        wait_drained();

        write_base($urandom());
        set_idling(IDLE_BOTH);
        queue_random_bytes(body_total - 70);
        queue_word(ACT_END, 8'($urandom));
        // block is stopped now, these must give nothing
        repeat (4) queue_word(1'($urandom), 8'($urandom));
        wait_drained();
        repeat (10) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
